>>> hdl/ewg_pkg.sv
// Shared constants, codes and interface types of the EWMA wear health grader.
package ewg_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int COUNT_WIDTH = 32;

    localparam int SMP_W  = 18;             // signed raw sample
    localparam int LVL_W  = FRAC_BITS + 1;  // 0 .. 1.0 inclusive
    localparam int LIFE_W = 15;             // 0 .. 25600
    localparam int PROD_W = 2 * LVL_W;      // |sample - level| * weight
    localparam int DIV_W  = 32;             // dividend / shifted divisor width
    localparam int QCNT_W = $clog2(LIFE_W);

    localparam logic [LVL_W-1:0]       Q_ONE          = LVL_W'(1) << FRAC_BITS;
    localparam logic [LVL_W-1:0]       WEIGHT_DEFAULT = LVL_W'(19661);
    localparam logic [LVL_W-1:0]       WARN_DEFAULT   = LVL_W'(45875);
    localparam logic [LVL_W-1:0]       END_DEFAULT    = LVL_W'(58982);
    localparam logic [LIFE_W-1:0]      LIFE_FULL      = LIFE_W'(25600);
    localparam logic [COUNT_WIDTH-1:0] COUNT_TOP      = '1;

    typedef enum logic [1:0] {
        CFG_NEW    = 2'd0,
        CFG_WARN   = 2'd1,
        CFG_END    = 2'd2,
        CFG_WEIGHT = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_WARN  = 2'd1,
        ST_ALARM = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_UPD,
        B_GRADE,
        B_DIV,
        B_OUT
    } t_bstate;

    // head of the sample queue as seen by the back end
    typedef struct packed {
        logic             valid;
        logic [LVL_W-1:0] data;
    } t_q_rd;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [LVL_W-1:0] span;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic [LIFE_W-1:0] quot;
    } t_div_rsp;

endpackage

>>> hdl/ewma_wear_health_grader.sv
// Top level of the EWMA wear health grader: configuration registers and wiring.
//
// One wear sample (signed Q16, clamped to 0..1.0) enters per transfer on the
// input channel (i_in_valid / o_in_stall / i_sample). The first sample after
// reset seeds the smoothed level, later ones move it by the smoothing weight.
// Each sample gives exactly one result transfer on the output channel
// (o_out_valid / i_out_stall): status, smoothed level, remaining life in
// 1/256 percent and the saturating batch count.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// must write it only while no sample is in flight, the block does not enforce
// this. A weight of 0 or above 1.0 stores 0.3 instead. The back end takes each
// sample through the idle, multiply, update, grade, divide and output states;
// in the divide state the serial remaining-life divider yields 15 quotient
// bits, one a cycle, and then the quotient is collected. When the life is 0
// or full the divide state is skipped. A two-entry queue lets the input
// accept while the back end works, and the result register lets the back
// end finish while the receiver stalls; a stalled result holds.
// Synchronous reset restores the default thresholds and weight, clears the
// level, the seeded flag, the count, the sample queue and the result register.
module ewma_wear_health_grader import ewg_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic signed [SMP_W-1:0] i_sample,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [1:0]              o_status,
    output logic [LVL_W-1:0]        o_smoothed_level,
    output logic [LIFE_W-1:0]       o_remaining_life,
    output logic [31:0]             o_batches_seen,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_idx,
    input  logic [LVL_W-1:0]        i_cfg_data
);

    logic [LVL_W-1:0] r_new_level;
    logic [LVL_W-1:0] r_warn_level;
    logic [LVL_W-1:0] r_end_level;
    logic [LVL_W-1:0] r_weight;
    t_q_rd            q_rd;
    logic             pop;
    t_div_req         div_req;
    t_div_rsp         div_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_new_level  <= '0;
            r_warn_level <= WARN_DEFAULT;
            r_end_level  <= END_DEFAULT;
            r_weight     <= WEIGHT_DEFAULT;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_NEW:    r_new_level  <= i_cfg_data;
                CFG_WARN:   r_warn_level <= i_cfg_data;
                CFG_END:    r_end_level  <= i_cfg_data;
                CFG_WEIGHT: begin
                    // drop illegal weights back to the default
                    r_weight <= (i_cfg_data != '0 && i_cfg_data <= Q_ONE)
                              ? i_cfg_data : WEIGHT_DEFAULT;
                end
                default: ;
            endcase
        end
    end

    ewg_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_stall  (o_in_stall),
        .i_sample (i_sample),
        .o_q      (q_rd),
        .i_pop    (pop)
    );

    ewg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    ewg_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q              (q_rd),
        .o_pop            (pop),
        .i_new_level      (r_new_level),
        .i_warn_level     (r_warn_level),
        .i_end_level      (r_end_level),
        .i_weight         (r_weight),
        .o_div_req        (div_req),
        .i_div_rsp        (div_rsp),
        .o_valid          (o_out_valid),
        .i_stall          (i_out_stall),
        .o_status         (o_status),
        .o_smoothed_level (o_smoothed_level),
        .o_remaining_life (o_remaining_life),
        .o_batches_seen   (o_batches_seen)
    );

    a_weight_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_weight != '0 && r_weight <= Q_ONE)
        else $error("smoothing weight register holds an illegal value");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_smoothed_level <= Q_ONE)
        else $error("smoothed level above 1.0");

    a_life_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_remaining_life <= LIFE_FULL)
        else $error("remaining life above full");

    a_alarm_no_life: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_ALARM) |-> o_remaining_life == '0)
        else $error("alarm status with remaining life left");

endmodule

>>> hdl/ewg_front.sv
// Front end: takes sample transfers, clamps them to 0..1.0 and queues them.
module ewg_front import ewg_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [SMP_W-1:0] i_sample,
    output t_q_rd                   o_q,
    input  logic                    i_pop
);

    logic [LVL_W-1:0] r_q [2];
    logic             r_wp, n_wp;
    logic             r_rp, n_rp;
    logic [1:0]       r_cnt, n_cnt;
    logic [LVL_W-1:0] clamped;
    logic             push;

    always_comb begin
        priority if (i_sample < 0) begin
            clamped = '0;
        end else if (i_sample > SMP_W'(signed'({1'b0, Q_ONE}))) begin
            clamped = Q_ONE;
        end else begin
            clamped = i_sample[LVL_W-1:0];
        end
    end

    assign o_stall = (r_cnt == 2'd2);
    assign push    = i_valid && !o_stall;
    assign o_q     = '{valid: (r_cnt != 2'd0), data: r_q[r_rp]};

    always_comb begin
        n_wp  = r_wp ^ push;
        n_rp  = r_rp ^ i_pop;
        n_cnt = r_cnt + 2'(push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= clamped;
        end
    end

endmodule

>>> hdl/ewg_div.sv
// Restoring serial divider for the remaining-life quotient, one bit a cycle.
module ewg_div import ewg_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy, n_busy;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic [DIV_W-1:0]  r_rem, n_rem;
    logic [DIV_W-1:0]  r_dvs, n_dvs;
    logic [LIFE_W-1:0] r_quot, n_quot;
    logic              fits;

    assign fits  = (r_rem >= r_dvs);
    assign o_rsp = '{busy: r_busy, quot: r_quot};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_quot = r_quot;
        if (i_req.start) begin
            // quotient is known to stay below 2^LIFE_W, so align the divisor there
            n_busy = 1'b1;
            n_cnt  = QCNT_W'(LIFE_W - 1);
            n_rem  = i_req.num;
            n_dvs  = DIV_W'(i_req.span) << (LIFE_W - 1);
            n_quot = '0;
        end else if (r_busy) begin
            n_rem  = fits ? r_rem - r_dvs : r_rem;
            n_quot = {r_quot[LIFE_W-2:0], fits};
            n_dvs  = r_dvs >> 1;
            n_cnt  = r_cnt - QCNT_W'(1);
            n_busy = (r_cnt != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
        r_quot <= n_quot;
    end

endmodule

>>> hdl/ewg_back.sv
// Back end: EWMA update, grading, remaining life and the result register.
module ewg_back import ewg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_q_rd              i_q,
    output logic               o_pop,
    input  logic [LVL_W-1:0]   i_new_level,
    input  logic [LVL_W-1:0]   i_warn_level,
    input  logic [LVL_W-1:0]   i_end_level,
    input  logic [LVL_W-1:0]   i_weight,
    output t_div_req           o_div_req,
    input  t_div_rsp           i_div_rsp,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic [LVL_W-1:0]   o_smoothed_level,
    output logic [LIFE_W-1:0]  o_remaining_life,
    output logic [31:0]        o_batches_seen
);

    t_bstate                r_state, n_state;
    logic                   r_seeded, n_seeded;
    logic [LVL_W-1:0]       r_level, n_level;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic [LVL_W-1:0]       r_smp, n_smp;
    logic                   r_up, n_up;
    logic [PROD_W-1:0]      r_prod, n_prod;
    t_status                r_status, n_status;
    logic [LIFE_W-1:0]      r_life, n_life;
    logic                   r_ovalid, n_ovalid;
    t_status                r_ostatus, n_ostatus;
    logic [LVL_W-1:0]       r_olevel, n_olevel;
    logic [LIFE_W-1:0]      r_olife, n_olife;
    logic [COUNT_WIDTH-1:0] r_ocount, n_ocount;

    logic [LVL_W-1:0]  diff;
    logic [PROD_W:0]   down_sum;
    logic [LVL_W-1:0]  step_up;
    logic [LVL_W-1:0]  step_dn;
    logic [LVL_W-1:0]  to_end;

    assign diff     = r_up ? (r_smp - r_level) : (r_level - r_smp);
    assign step_up  = r_prod[FRAC_BITS +: LVL_W];
    // round the downward step up so the level moves by floor
    assign down_sum = (PROD_W+1)'(r_prod) + (PROD_W+1)'(Q_ONE - LVL_W'(1));
    assign step_dn  = down_sum[FRAC_BITS +: LVL_W];
    assign to_end   = i_end_level - r_level;

    always_comb begin
        n_state   = r_state;
        n_seeded  = r_seeded;
        n_level   = r_level;
        n_count   = r_count;
        n_smp     = r_smp;
        n_up      = r_up;
        n_prod    = r_prod;
        n_status  = r_status;
        n_life    = r_life;
        n_ovalid  = r_ovalid && i_stall;
        n_ostatus = r_ostatus;
        n_olevel  = r_olevel;
        n_olife   = r_olife;
        n_ocount  = r_ocount;
        o_pop     = 1'b0;
        o_div_req = '{start: 1'b0,
                      num:   DIV_W'(to_end) * DIV_W'(LIFE_FULL),
                      span:  i_end_level - i_new_level};
        unique case (r_state)
            B_IDLE: begin
                if (i_q.valid) begin
                    o_pop   = 1'b1;
                    n_smp   = i_q.data;
                    n_up    = (i_q.data >= r_level);
                    n_state = B_MUL;
                end
            end
            B_MUL: begin
                n_prod  = PROD_W'(diff) * PROD_W'(i_weight);
                n_state = B_UPD;
            end
            B_UPD: begin
                priority if (!r_seeded) begin
                    n_level = r_smp;
                end else if (r_up) begin
                    n_level = r_level + step_up;
                end else begin
                    n_level = r_level - step_dn;
                end
                n_seeded = 1'b1;
                if (r_count != COUNT_TOP) begin
                    n_count = r_count + COUNT_WIDTH'(1);
                end
                n_state = B_GRADE;
            end
            B_GRADE: begin
                priority if (r_level >= i_end_level) begin
                    n_status = ST_ALARM;
                end else if (r_level >= i_warn_level) begin
                    n_status = ST_WARN;
                end else begin
                    n_status = ST_OK;
                end
                priority if (i_end_level <= i_new_level || r_level >= i_end_level) begin
                    n_life  = '0;
                    n_state = B_OUT;
                end else if (r_level <= i_new_level) begin
                    n_life  = LIFE_FULL;
                    n_state = B_OUT;
                end else begin
                    o_div_req.start = 1'b1;
                    n_state         = B_DIV;
                end
            end
            B_DIV: begin
                if (!i_div_rsp.busy) begin
                    n_life  = i_div_rsp.quot;
                    n_state = B_OUT;
                end
            end
            B_OUT: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_olevel  = r_level;
                    n_olife   = r_life;
                    n_ocount  = r_count;
                    n_state   = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_seeded <= 1'b0;
            r_level  <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_seeded <= n_seeded;
            r_level  <= n_level;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_smp     <= n_smp;
        r_up      <= n_up;
        r_prod    <= n_prod;
        r_status  <= n_status;
        r_life    <= n_life;
        r_ostatus <= n_ostatus;
        r_olevel  <= n_olevel;
        r_olife   <= n_olife;
        r_ocount  <= n_ocount;
    end

    assign o_valid          = r_ovalid;
    assign o_status         = r_ostatus;
    assign o_smoothed_level = r_olevel;
    assign o_remaining_life = r_olife;
    assign o_batches_seen   = r_ocount[31:0];

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the EWMA wear health grader.
`timescale 1ns / 1ps

module testbench;
    import ewg_pkg::*;

    localparam int RAND_PHASES  = 6;
    localparam int PHASE_ITEMS  = 175;
    localparam int HOLD_OFF     = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct {
        t_status           status;
        logic [LVL_W-1:0]  level;
        logic [LIFE_W-1:0] life;
        logic [31:0]       batches;
    } t_grade;

    // Tracks thresholds, weight and smoothed level; holds the grades still owed.
    class health_predictor;
        logic [LVL_W-1:0]       new_lvl;
        logic [LVL_W-1:0]       warn_lvl;
        logic [LVL_W-1:0]       end_lvl;
        logic [LVL_W-1:0]       weight;
        logic [LVL_W-1:0]       lvl;
        bit                     primed;
        logic [COUNT_WIDTH-1:0] count;
        t_grade                 owed[$];
        int                     errors;
        int                     checked;
        int                     per_status[3];

        function new();
            new_lvl  = '0;
            warn_lvl = WARN_DEFAULT;
            end_lvl  = END_DEFAULT;
            weight   = WEIGHT_DEFAULT;
            lvl      = '0;
            primed   = 1'b0;
            count    = '0;
            errors   = 0;
            checked  = 0;
            per_status = '{0, 0, 0};
        endfunction

        function void set_reg(input t_cfg_idx idx, input logic [LVL_W-1:0] v);
            case (idx)
                CFG_NEW:    new_lvl  = v;
                CFG_WARN:   warn_lvl = v;
                CFG_END:    end_lvl  = v;
                CFG_WEIGHT: weight   = (v >= 1 && v <= Q_ONE) ? v : WEIGHT_DEFAULT;
                default: ;
            endcase
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function void take_sample(input logic signed [SMP_W-1:0] raw);
            t_grade  g;
            longint  s;
            longint  cur;
            longint  w;
            longint  e;
            longint  n;
            longint  r;
            s   = raw;
            cur = longint'(lvl);
            w   = longint'(weight);
            e   = longint'(end_lvl);
            n   = longint'(new_lvl);
            if (s < 0)
                s = 0;
            else if (s > longint'(Q_ONE))
                s = longint'(Q_ONE);
            if (!primed) begin
                cur    = s;
                primed = 1'b1;
            end else if (s >= cur) begin
                cur = cur + (((s - cur) * w) >>> FRAC_BITS);
            end else begin
                // round the downward step up so the level still floors
                cur = cur - (((cur - s) * w + longint'(Q_ONE) - 1) >>> FRAC_BITS);
            end
            lvl = cur[LVL_W-1:0];
            if (count != COUNT_TOP)
                count = count + 1'b1;

            if (cur >= e)
                g.status = ST_ALARM;
            else if (cur >= longint'(warn_lvl))
                g.status = ST_WARN;
            else
                g.status = ST_OK;
            if (e <= n || cur >= e) begin
                g.life = '0;
            end else begin
                r = (longint'(LIFE_FULL) * (e - cur)) / (e - n);
                g.life = (r > longint'(LIFE_FULL)) ? LIFE_FULL : r[LIFE_W-1:0];
            end
            g.level   = lvl;
            g.batches = count[31:0];
            owed.push_back(g);
        endfunction

        function void check_grade(input logic [1:0] st, input logic [LVL_W-1:0] level,
                                  input logic [LIFE_W-1:0] life, input logic [31:0] batches);
            t_grade g;
            if (owed.size() == 0) begin
                $display("%0t: grade with none owed (status %0d level %0d life %0d count %0d)",
                         $time, st, level, life, batches);
                errors++;
                return;
            end
            g = owed.pop_front();
            checked++;
            if (g.status <= ST_ALARM)
                per_status[g.status]++;
            if (st !== g.status) begin
                $display("%0t: status expected %0d got %0d", $time, g.status, st);
                errors++;
            end
            if (level !== g.level) begin
                $display("%0t: level expected %0d got %0d", $time, g.level, level);
                errors++;
            end
            if (life !== g.life) begin
                $display("%0t: remaining life expected %0d got %0d", $time, g.life, life);
                errors++;
            end
            if (batches !== g.batches) begin
                $display("%0t: batch count expected %0d got %0d", $time, g.batches, batches);
                errors++;
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic signed [SMP_W-1:0] i_sample;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic [1:0]              o_status;
    logic [LVL_W-1:0]        o_smoothed_level;
    logic [LIFE_W-1:0]       o_remaining_life;
    logic [31:0]             o_batches_seen;
    logic                    i_cfg_we;
    logic [1:0]              i_cfg_idx;
    logic [LVL_W-1:0]        i_cfg_data;

    health_predictor hp;
    bit              calm;
    bit              hold_off_req;
    int              hold_offs;
    int              samples_sent;
    int              reg_writes;
    longint          cycles;

    ewma_wear_health_grader uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_sample         (i_sample),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_smoothed_level (o_smoothed_level),
        .o_remaining_life (o_remaining_life),
        .o_batches_seen   (o_batches_seen),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d grades still owed", $time, hp.pending());
            $display("simulation failed");
            $finish;
        end
    end

    // Values settle by the falling edge; a grade transfers at the next rising edge.
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            hp.check_grade(o_status, o_smoothed_level, o_remaining_life, o_batches_seen);
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Receiver: alternating stall and free stretches, with a long hold-off on request.
    initial begin : result_sink
        int  len;
        bit  stalled;
        int  r;
        stalled = 1'b0;
        @(posedge i_clk);
        forever begin
            r = $urandom_range(0, 99);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_offs++;
                stalled = 1'b1;
                len     = HOLD_OFF;
            end else if (stalled || r < 35) begin
                stalled = 1'b0;
                len     = (r % 10 == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
            end else begin
                stalled = 1'b1;
                len     = (r > 95) ? $urandom_range(20, 60) :
                          (r > 80) ? $urandom_range(4, 12) : $urandom_range(1, 3);
            end
            i_out_stall <= stalled;
            repeat (len) @(posedge i_clk);
        end
    end

    task automatic send_sample(input logic signed [SMP_W-1:0] s);
        int  gap;
        bit  held;
        gap = calm ? 0 : idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= s;
        do begin
            @(negedge i_clk);
            held = o_in_stall;
            @(posedge i_clk);
        end while (held);
        hp.take_sample(s);
        samples_sent++;
    endtask

    // Drop valid and wait until every owed grade has transferred.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (hp.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [LVL_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        hp.set_reg(idx, v);
        reg_writes++;
        @(posedge i_clk);
    endtask

    function automatic logic [LVL_W-1:0] pick_level(input int lo, input int hi);
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return '0;
            1:       return Q_ONE;
            2:       return LVL_W'($urandom_range(0, 131071));
            default: return LVL_W'($urandom_range(lo, hi));
        endcase
    endfunction

    function automatic logic [LVL_W-1:0] pick_weight();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return LVL_W'(1);
            1:       return Q_ONE;
            2:       return '0;
            3:       return LVL_W'($urandom_range(65537, 131071));
            4:       return LVL_W'($urandom_range(0, 131071));
            default: return LVL_W'($urandom_range(2000, 40000));
        endcase
    endfunction

    function automatic logic signed [SMP_W-1:0] pick_sample();
        int r;
        int v;
        int t;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            v = $urandom_range(0, 65536);
        end else if (r < 75) begin
            t = (r < 62) ? int'(hp.warn_lvl) : (r < 69) ? int'(hp.end_lvl) : int'(hp.lvl);
            v = t + $urandom_range(0, 400) - 200;
        end else if (r < 90) begin
            v = $urandom_range(0, 262143);
            v = v - ((v >= 131072) ? 262144 : 0);
        end else begin
            case (r % 5)
                0:       v = 0;
                1:       v = 65536;
                2:       v = -131072;
                3:       v = 131071;
                default: v = 65537;
            endcase
        end
        if (v > 131071)
            v = 131071;
        return SMP_W'(v);
    endfunction

    initial begin : stimulus
        t_cfg_idx order[4];
        int       k;
        hp           = new();
        calm         = 1'b0;
        hold_off_req = 1'b0;
        hold_offs    = 0;
        samples_sent = 0;
        reg_writes   = 0;
        cycles       = 0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_sample     = '0;
        i_out_stall  = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_NEW;
        i_cfg_data   = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults: seeding from an over-range sample, then both clamps and the thresholds
        send_sample(18'sd131071);
        send_sample(-18'sd131072);
        send_sample(18'sd0);
        send_sample(18'sd65537);
        send_sample(-18'sd1);
        send_sample(18'sd65536);
        send_sample(18'sd45875);
        send_sample(18'sd58982);
        send_sample(18'sd1);
        drain();

        // full weight, thresholds above 1.0, level falling below the new level
        write_reg(CFG_WEIGHT, Q_ONE);
        write_reg(CFG_NEW, LVL_W'(10000));
        write_reg(CFG_WARN, LVL_W'(131071));
        write_reg(CFG_END, LVL_W'(100000));
        send_sample(18'sd5000);
        send_sample(18'sd65536);
        send_sample(18'sd0);
        drain();

        // zero weight falls back to the default; end equal to new gives no life
        write_reg(CFG_WEIGHT, '0);
        write_reg(CFG_END, LVL_W'(10000));
        write_reg(CFG_WARN, '0);
        send_sample(18'sd30000);
        send_sample(18'sd2000);
        drain();

        // all-ones weight is rejected; end below new
        write_reg(CFG_WEIGHT, LVL_W'(131071));
        write_reg(CFG_NEW, Q_ONE);
        write_reg(CFG_END, '0);
        send_sample(18'sd40000);
        drain();

        // just above 1.0 is rejected, then the smallest legal weight
        write_reg(CFG_WEIGHT, LVL_W'(65537));
        write_reg(CFG_WEIGHT, LVL_W'(1));
        write_reg(CFG_NEW, '0);
        write_reg(CFG_END, Q_ONE);
        write_reg(CFG_WARN, LVL_W'(32768));
        send_sample(18'sd65536);
        send_sample(18'sd0);
        send_sample(18'sd131071);
        drain();

        for (int p = 0; p < RAND_PHASES; p++) begin
            order = '{CFG_NEW, CFG_WARN, CFG_END, CFG_WEIGHT};
            order.shuffle();
            for (k = 0; k < 4; k++) begin
                case (order[k])
                    CFG_NEW:    write_reg(CFG_NEW, pick_level(0, 20000));
                    CFG_WARN:   write_reg(CFG_WARN, pick_level(25000, 60000));
                    CFG_END:    write_reg(CFG_END, pick_level(40000, 65536));
                    default:    write_reg(CFG_WEIGHT, pick_weight());
                endcase
            end
            calm = (p == 3);
            if (p == 1 || p == 4)
                hold_off_req = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_sample(pick_sample());
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d samples, %0d register writes, %0d long receiver hold-offs",
                 samples_sent, reg_writes, hold_offs);
        $display("grades checked %0d: ok %0d, warn %0d, alarm %0d",
                 hp.checked, hp.per_status[0], hp.per_status[1], hp.per_status[2]);
        if (hp.errors == 0 && hp.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
